[src/rgbbmp_pkg.sv]
// Shared types, constants and helper functions for the RGB565 to BMP24 stream core.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rgbbmp_pkg;

  localparam int unsigned DefMaxDim   = 512;
  localparam int unsigned DefFbPixels = 131072;

  localparam int unsigned DimW = 10;  // size register width
  localparam int unsigned StrW = 12;  // row stride in bytes, up to 3 * 1023 rounded up
  localparam int unsigned PosW = 22;  // file size and positions
  localparam int unsigned QW   = 10;  // row number, one quotient bit per divider stage
  localparam int unsigned CrdW = 13;  // signed framebuffer coordinates
  localparam int unsigned AdrW = 25;  // pixel address before the range check

  localparam logic [PosW-1:0] HdrBytes = PosW'(54);

  typedef enum logic [2:0] {
    REG_SCREEN_W = 3'd0,
    REG_SCREEN_H = 3'd1,
    REG_NATIVE_W = 3'd2,
    REG_NATIVE_H = 3'd3,
    REG_ROTATION = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_e;

  // Item state that travels down the whole pipeline.
  typedef struct packed {
    logic            vld;
    logic            wr;
    logic            beyond;
    logic            hdr;
    logic [7:0]      hbyte;
    logic [16:0]     pidx;
    logic [15:0]     pval;
    logic [PosW-1:0] rem;
    logic [QW-1:0]   row;
  } pl_t;

  function automatic logic [7:0] le_byte(input logic [PosW-1:0] v, input logic [1:0] sel);
    logic [31:0] w;
    begin
      w = 32'(v);
      le_byte = w[8*sel +: 8];
    end
  endfunction

  function automatic logic [7:0] header_byte(input logic [5:0] pos,
                                             input logic [PosW-1:0] fsize,
                                             input logic [DimW-1:0] w,
                                             input logic [DimW-1:0] h,
                                             input logic [PosW-1:0] isize);
    logic [7:0] b;
    logic [1:0] sel;
    begin
      b   = 8'd0;
      sel = pos[1:0] - 2'd2;
      if (pos == 6'd0) b = 8'h42;
      else if (pos == 6'd1) b = 8'h4D;
      else if (pos >= 6'd2 && pos < 6'd6) b = le_byte(fsize, sel);
      else if (pos == 6'd10) b = 8'd54;
      else if (pos == 6'd14) b = 8'd40;
      else if (pos >= 6'd18 && pos < 6'd22) b = le_byte(PosW'(w), sel);
      else if (pos >= 6'd22 && pos < 6'd26) b = le_byte(PosW'(h), sel);
      else if (pos == 6'd26) b = 8'd1;
      else if (pos == 6'd28) b = 8'd24;
      else if (pos >= 6'd34 && pos < 6'd38) b = le_byte(isize, sel);
      header_byte = b;
    end
  endfunction

  // x * 255 / 31 = 8x + 7x / 31; the small quotient uses a reciprocal that is exact here.
  function automatic logic [7:0] expand5(input logic [4:0] x);
    logic [7:0]  t;
    logic [16:0] p;
    begin
      t = 8'(x) * 8'd7;
      p = 17'(t) * 17'd265;
      expand5 = {x, 3'b000} + 8'(p[16:13]);
    end
  endfunction

  // x * 255 / 63 = 4x + x / 21.
  function automatic logic [7:0] expand6(input logic [5:0] x);
    logic [1:0] q;
    begin
      if (x >= 6'd63) q = 2'd3;
      else if (x >= 6'd42) q = 2'd2;
      else if (x >= 6'd21) q = 2'd1;
      else q = 2'd0;
      expand6 = {x, 2'b00} + 8'(q);
    end
  endfunction

endpackage

[src/rgbbmp_div.sv]
// Pipelined restoring divider: pixel position by row stride, one quotient bit per stage.
// Depends on rgbbmp_pkg for the pipeline item type.
`timescale 1ns / 1ps

module rgbbmp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [rgbbmp_pkg::StrW-1:0] stride_i,
  input  rgbbmp_pkg::pl_t             in_i,
  output rgbbmp_pkg::pl_t             out_o
);
  import rgbbmp_pkg::*;

  pl_t st_q [QW];
  pl_t st_d [QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int unsigned K = QW - 1 - i;
    logic [PosW:0] dvs;
    pl_t           prev;

    if (i == 0) begin : g_first
      assign prev = in_i;
    end else begin : g_next
      assign prev = st_q[i-1];
    end

    assign dvs = (PosW + 1)'(stride_i) << K;

    always_comb begin
      st_d[i] = prev;
      if ((PosW + 1)'(prev.rem) >= dvs) begin
        st_d[i].rem    = prev.rem - PosW'(dvs);
        st_d[i].row[K] = 1'b1;
      end else begin
        st_d[i].row[K] = 1'b0;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[i] <= '0;
      end else if (en_i) begin
        st_q[i] <= st_d[i];
      end
    end
  end

  assign out_o = st_q[QW-1];

  // An image byte leaves the divider with its remainder inside one row.
  property p_rem_in_row;
    @(posedge clk_i) disable iff (!rst_ni)
      (out_o.vld && !out_o.wr && !out_o.hdr && !out_o.beyond && stride_i != '0
       && $stable(stride_i))
      |-> (out_o.rem < PosW'(stride_i));
  endproperty
  a_rem_in_row: assert property (p_rem_in_row) else $error("divider remainder not below stride");

endmodule

[src/rgb565_framebuffer_to_bmp24_stream_core.sv]
// Top level of the RGB565 framebuffer to 24-bit BMP byte stream core.
// Depends on rgbbmp_pkg and instantiates the stride divider rgbbmp_div.
`timescale 1ns / 1ps

// Usage:
// The input channel (in_valid_i / in_stall_o) carries one command per transfer. A write
// (cmd_i = 1) stores pixel_value_i at pixel_index_i and returns nothing. A read (cmd_i = 0)
// asks for the BMP file byte at file_position_i and returns exactly one transfer on the
// output channel (out_valid_o / out_stall_i) with byte_value_o and beyond_end_o.
// Results leave in request order. A read passes through the capture and classify stages,
// the ten one-bit stages of the stride divider and the column, rotation, address, memory
// and output stages. One command is taken every cycle while the output is not stalled.
// Reads see every earlier write, because both reach the frame memory in the same stage.
// When the receiver stalls a valid output the output register holds, the whole
// pipeline freezes and in_stall_o rises in the same cycle; nothing is dropped or repeated.
// Reset empties the pipeline and loads 320 x 240, unrotated, into the size registers.
// The frame memory is not cleared; pixels must be written before they are read.
// Write size registers via cfg_we_i only with no read in flight; the core does not check.
module rgb565_framebuffer_to_bmp24_stream_core #(
  parameter int unsigned MAX_DIM   = rgbbmp_pkg::DefMaxDim,
  parameter int unsigned FB_PIXELS = rgbbmp_pkg::DefFbPixels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [19:0] file_position_i,
  input  logic [16:0] pixel_index_i,
  input  logic [15:0] pixel_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  byte_value_o,
  output logic        beyond_end_o
);
  import rgbbmp_pkg::*;

  localparam int unsigned AW = (FB_PIXELS > 1) ? $clog2(FB_PIXELS) : 1;

  // Configuration registers
  logic [DimW-1:0] sw_q, sh_q, nw_q, nh_q;
  logic [1:0]      rot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q  <= DimW'(320);
      sh_q  <= DimW'(240);
      nw_q  <= DimW'(320);
      nh_q  <= DimW'(240);
      rot_q <= ROT_0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_SCREEN_W: sw_q  <= cfg_wdata_i;
        REG_SCREEN_H: sh_q  <= cfg_wdata_i;
        REG_NATIVE_W: nw_q  <= cfg_wdata_i;
        REG_NATIVE_H: nh_q  <= cfg_wdata_i;
        REG_ROTATION: rot_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    begin
      if (v == '0) clamp_dim = DimW'(1);
      else if (32'(v) > MAX_DIM) clamp_dim = DimW'(MAX_DIM);
      else clamp_dim = v;
    end
  endfunction

  // Derived sizes, refreshed every cycle from the registers.
  logic [DimW-1:0] sw_c, sh_c, nw_c, nh_c;
  logic [StrW-1:0] sw3_c, stride_c;
  logic [StrW-1:0] sw3_q, stride_q;
  logic [PosW-1:0] img_q, file_q;
  logic [DimW-1:0] swd_q, shd_q, nwd_q, nhd_q;
  logic [1:0]      rotd_q;

  always_comb begin
    sw_c     = clamp_dim(sw_q);
    sh_c     = clamp_dim(sh_q);
    nw_c     = clamp_dim(nw_q);
    nh_c     = clamp_dim(nh_q);
    sw3_c    = StrW'(sw_c) * StrW'(3);
    stride_c = (sw3_c + StrW'(3)) & ~StrW'(3);
  end

  always_ff @(posedge clk_i) begin
    sw3_q    <= sw3_c;
    stride_q <= stride_c;
    img_q    <= PosW'(stride_c) * PosW'(sh_c);
    file_q   <= PosW'(stride_c) * PosW'(sh_c) + HdrBytes;
    swd_q    <= sw_c;
    shd_q    <= sh_c;
    nwd_q    <= nw_c;
    nhd_q    <= nh_c;
    rotd_q   <= rot_q;
  end

  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Stage 0: capture the transfer.
  pl_t s0_q, s0_d, s1_q, s1_d, div_out;

  always_comb begin
    s0_d      = '0;
    s0_d.vld  = in_valid_i;
    s0_d.wr   = cmd_i;
    s0_d.pidx = pixel_index_i;
    s0_d.pval = pixel_value_i;
    s0_d.rem  = PosW'(file_position_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_q <= '0;
    end else if (en) begin
      s0_q <= s0_d;
    end
  end

  // Stage 1: classify the position and build header bytes.
  always_comb begin
    s1_d        = s0_q;
    s1_d.beyond = (s0_q.rem >= file_q);
    s1_d.hdr    = (s0_q.rem < HdrBytes);
    s1_d.hbyte  = header_byte(s0_q.rem[5:0], file_q, swd_q, shd_q, img_q);
    s1_d.rem    = s0_q.rem - HdrBytes;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (en) begin
      s1_q <= s1_d;
    end
  end

  rgbbmp_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .stride_i (stride_q),
    .in_i     (s1_q),
    .out_o    (div_out)
  );

  // Stage C: column by three through a reciprocal, exact for offsets below 3072.
  pl_t         sc_q, sd_q, se_q, sf_q;
  logic [23:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sc_q <= '0;
    end else if (en) begin
      sc_q <= div_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 24'(div_out.rem[StrW-1:0]) * 24'd2731;
    end
  end

  // Stage D: channel, padding and rotation.
  logic [10:0]            sx;
  logic [StrW-1:0]        sx3;
  logic signed [CrdW-1:0] sxs, sys, bx_d, by_d;
  logic signed [CrdW-1:0] bx_q, by_q;
  logic [1:0]             ch_d, ch_q, ch_e, ch_f;
  logic                   pad_q;

  always_comb begin
    sx   = prod_q[23:13];
    sx3  = StrW'(sx) * StrW'(3);
    ch_d = 2'(sc_q.rem[StrW-1:0] - sx3);
    sxs  = CrdW'(sx);
    sys  = CrdW'(shd_q) - CrdW'(1) - CrdW'(sc_q.row);
    case (rot_e'(rotd_q))
      ROT_90: begin
        bx_d = CrdW'(nwd_q) - CrdW'(1) - sys;
        by_d = sxs;
      end
      ROT_180: begin
        bx_d = CrdW'(nwd_q) - CrdW'(1) - sxs;
        by_d = CrdW'(nhd_q) - CrdW'(1) - sys;
      end
      ROT_270: begin
        bx_d = sys;
        by_d = CrdW'(nhd_q) - CrdW'(1) - sxs;
      end
      default: begin
        bx_d = sxs;
        by_d = sys;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_q <= '0;
    end else if (en) begin
      sd_q <= sc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bx_q  <= bx_d;
      by_q  <= by_d;
      ch_q  <= ch_d;
      pad_q <= (sc_q.rem[StrW-1:0] >= sw3_q);
    end
  end

  // Stage E: framebuffer address and its range check.
  logic [AdrW-1:0] addr_d, addr_q;
  logic            zero_q;

  assign addr_d = AdrW'(by_q[CrdW-2:0]) * AdrW'(nwd_q) + AdrW'(bx_q[CrdW-2:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      se_q <= '0;
    end else if (en) begin
      se_q <= sd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      addr_q <= addr_d;
      ch_e   <= ch_q;
      zero_q <= pad_q || bx_q[CrdW-1] || by_q[CrdW-1] || (32'(addr_d) >= FB_PIXELS);
    end
  end

  // Stage F: frame memory. Writes and reads meet here in command order.
  logic [15:0] mem [FB_PIXELS];
  logic [15:0] px_q;
  logic        zero_f;

  always_ff @(posedge clk_i) begin
    if (en && se_q.vld && se_q.wr && (32'(se_q.pidx) < FB_PIXELS)) begin
      mem[AW'(se_q.pidx)] <= se_q.pval;
    end
    if (en) begin
      px_q <= mem[AW'(addr_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sf_q <= '0;
    end else if (en) begin
      sf_q <= se_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ch_f   <= ch_e;
      zero_f <= zero_q;
    end
  end

  // Output stage: channel expansion in B, G, R order.
  logic [7:0] pix_byte, byte_d, byte_q;
  logic       beyond_q;

  always_comb begin
    case (ch_f)
      2'd0:    pix_byte = expand5(px_q[4:0]);
      2'd1:    pix_byte = expand6(px_q[10:5]);
      default: pix_byte = expand5(px_q[15:11]);
    endcase
    if (sf_q.beyond || zero_f) byte_d = 8'd0;
    else byte_d = pix_byte;
    if (sf_q.hdr && !sf_q.beyond) byte_d = sf_q.hbyte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= sf_q.vld && !sf_q.wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      byte_q   <= byte_d;
      beyond_q <= sf_q.beyond;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign byte_value_o = byte_q;
  assign beyond_end_o = beyond_q;

  a_beyond_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && beyond_end_o) |-> (byte_value_o == 8'd0))
    else $error("byte past the end is not zero");

  a_stall_only_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output is free");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> ($stable(sf_q.vld) && $stable(se_q.vld) && $stable(s0_q.vld)))
    else $error("pipeline moved during a stall");

endmodule

[verif/bmp_stream_checker.sv]
// Checker for the RGB565 to BMP24 stream core: watches the config port and both channels,
// predicts each file byte from its own frame store copy and compares in order.
// Depends on rgbbmp_pkg for the register index and rotation codes.
`timescale 1ns / 1ps

module bmp_stream_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [9:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        cmd_i,
  input  logic [19:0] file_position_i,
  input  logic [16:0] pixel_index_i,
  input  logic [15:0] pixel_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  byte_value_i,
  input  logic        beyond_end_i,
  output int          fail_count_o,
  output int          pending_o
);
  import rgbbmp_pkg::*;

  localparam int FramePixels = 131072;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       beyond_end;
  } file_byte_t;

  logic [15:0]  frame_copy [FramePixels];
  logic [9:0]   scr_w, scr_h, nat_w, nat_h;
  rot_e         rot;
  file_byte_t   byte_queue[$];

  function automatic int clamp_dim(input logic [9:0] v);
    if (v == 10'd0) return 1;
    if (v > 10'd512) return 512;
    return int'(v);
  endfunction

  function automatic logic [7:0] le_part(input int v, input int sel);
    return 8'((v >> (8 * sel)) & 255);
  endfunction

  function automatic file_byte_t predict_byte(input int pos);
    file_byte_t r;
    int sw, sh, nw, nh, stride, img, fsz;
    int p, row, off, sx, ch, sy, bx, by, addr, r5, g6, b5;
    logic [15:0] px;
    sw = clamp_dim(scr_w);
    sh = clamp_dim(scr_h);
    nw = clamp_dim(nat_w);
    nh = clamp_dim(nat_h);
    stride = ((sw * 3 + 3) / 4) * 4;
    img = stride * sh;
    fsz = 54 + img;
    r = '0;
    if (pos >= fsz) begin
      r.beyond_end = 1'b1;
      return r;
    end
    if (pos < 54) begin
      if (pos == 0) r.byte_value = 8'h42;
      else if (pos == 1) r.byte_value = 8'h4D;
      else if (pos >= 2 && pos < 6) r.byte_value = le_part(fsz, pos - 2);
      else if (pos >= 10 && pos < 14) r.byte_value = le_part(54, pos - 10);
      else if (pos >= 14 && pos < 18) r.byte_value = le_part(40, pos - 14);
      else if (pos >= 18 && pos < 22) r.byte_value = le_part(sw, pos - 18);
      else if (pos >= 22 && pos < 26) r.byte_value = le_part(sh, pos - 22);
      else if (pos == 26) r.byte_value = 8'd1;
      else if (pos == 28) r.byte_value = 8'd24;
      else if (pos >= 34 && pos < 38) r.byte_value = le_part(img, pos - 34);
      return r;
    end
    p = pos - 54;
    row = p / stride;
    off = p % stride;
    // Bytes that pad a row out to four come back as zero.
    if (off >= sw * 3) return r;
    sx = off / 3;
    ch = off % 3;
    sy = sh - 1 - row;
    bx = sx;
    by = sy;
    case (rot)
      ROT_90: begin
        bx = nw - 1 - sy;
        by = sx;
      end
      ROT_180: begin
        bx = nw - 1 - sx;
        by = nh - 1 - sy;
      end
      ROT_270: begin
        bx = sy;
        by = nh - 1 - sx;
      end
      default: ;
    endcase
    px = 16'h0000;
    if (bx >= 0 && by >= 0) begin
      addr = by * nw + bx;
      if (addr < FramePixels) px = frame_copy[addr];
    end
    r5 = int'(px[15:11]);
    g6 = int'(px[10:5]);
    b5 = int'(px[4:0]);
    if (ch == 0) r.byte_value = 8'((b5 * 255) / 31);
    else if (ch == 1) r.byte_value = 8'((g6 * 255) / 63);
    else r.byte_value = 8'((r5 * 255) / 31);
    return r;
  endfunction

  assign pending_o = byte_queue.size();

  always @(posedge clk_i or negedge rst_ni) begin
    file_byte_t exp_b;
    if (!rst_ni) begin
      scr_w = 10'd320;
      scr_h = 10'd240;
      nat_w = 10'd320;
      nat_h = 10'd240;
      rot = ROT_0;
      fail_count_o = 0;
      byte_queue.delete();
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_SCREEN_W: scr_w = cfg_wdata_i;
          REG_SCREEN_H: scr_h = cfg_wdata_i;
          REG_NATIVE_W: nat_w = cfg_wdata_i;
          REG_NATIVE_H: nat_h = cfg_wdata_i;
          REG_ROTATION: rot = rot_e'(cfg_wdata_i[1:0]);
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (byte_queue.size() == 0) begin
          $display("%0t: unexpected result byte %0h beyond %0b", $time, byte_value_i,
                   beyond_end_i);
          fail_count_o++;
        end else begin
          exp_b = byte_queue.pop_front();
          if (exp_b.byte_value !== byte_value_i) begin
            $display("%0t: byte_value expected %0h actual %0h", $time, exp_b.byte_value,
                     byte_value_i);
            fail_count_o++;
          end
          if (exp_b.beyond_end !== beyond_end_i) begin
            $display("%0t: beyond_end expected %0b actual %0b", $time, exp_b.beyond_end,
                     beyond_end_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (cmd_i) frame_copy[pixel_index_i] = pixel_value_i;
        else byte_queue.push_back(predict_byte(int'(file_position_i)));
      end
    end
  end

endmodule

[verif/tb_rgb565_framebuffer_to_bmp24_stream_core.sv]
// Top of the testbench for the RGB565 to BMP24 stream core: clock, reset, stimulus,
// stall patterns and verdict. Depends on rgbbmp_pkg, the core and bmp_stream_checker.
`timescale 1ns / 1ps

module tb_rgb565_framebuffer_to_bmp24_stream_core;
  import rgbbmp_pkg::*;

  localparam int WatchLimit = 3000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [9:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        cmd_i = 1'b0;
  logic [19:0] file_position_i = '0;
  logic [16:0] pixel_index_i = '0;
  logic [15:0] pixel_value_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  byte_value_o;
  logic        beyond_end_o;
  int          fail_count, pending;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          watch_cnt = 0;
  int          file_bytes = 54 + 960 * 240;
  int          cur_sw = 320;
  int          cur_sh = 240;
  int          cur_nw = 320;
  int          cur_nh = 240;
  rot_e        cur_rot = ROT_0;
  bit          written [131072];

  always #2 clk_i = ~clk_i;

  rgb565_framebuffer_to_bmp24_stream_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .cmd_i, .file_position_i, .pixel_index_i, .pixel_value_i,
    .out_valid_o, .out_stall_i, .byte_value_o, .beyond_end_o
  );

  bmp_stream_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .cmd_i, .file_position_i, .pixel_index_i,
    .pixel_value_i, .out_valid_i(out_valid_o), .out_stall_i, .byte_value_i(byte_value_o),
    .beyond_end_i(beyond_end_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  // Ends the run if nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      watch_cnt <= 0;
    end else if (watch_cnt >= WatchLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      watch_cnt <= watch_cnt + 1;
    end
  end

  // Receiver: short random stalls, and one long hold-off when asked.
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (60) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  function automatic int clamp_size(input int v);
    int m;
    m = v % 1024;
    if (m == 0) return 1;
    if (m > 512) return 512;
    return m;
  endfunction

  // Frame store address behind an image byte, or -1 when the byte reads no stored pixel.
  function automatic int pixel_addr(input int pos);
    int stride, p, row, off, sx, sy, bx, by, addr;
    stride = ((cur_sw * 3 + 3) / 4) * 4;
    if (pos < 54 || pos >= file_bytes) return -1;
    p = pos - 54;
    row = p / stride;
    off = p % stride;
    if (off >= cur_sw * 3) return -1;
    sx = off / 3;
    sy = cur_sh - 1 - row;
    bx = sx;
    by = sy;
    case (cur_rot)
      ROT_90: begin
        bx = cur_nw - 1 - sy;
        by = sx;
      end
      ROT_180: begin
        bx = cur_nw - 1 - sx;
        by = cur_nh - 1 - sy;
      end
      ROT_270: begin
        bx = sy;
        by = cur_nh - 1 - sx;
      end
      default: ;
    endcase
    if (bx < 0 || by < 0) return -1;
    addr = by * cur_nw + bx;
    if (addr >= 131072) return -1;
    return addr;
  endfunction

  task automatic send_item(input logic is_wr, input int pos, input int idx, input int val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    cmd_i           <= is_wr;
    file_position_i <= 20'(pos);
    pixel_index_i   <= 17'(idx);
    pixel_value_i   <= 16'(val);
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic write_pixel(input int idx, input int val);
    written[idx] = 1'b1;
    send_item(1'b1, $urandom_range(0, 1048575), idx, val);
  endtask

  // A pixel byte is only asked for once its pixel has been written.
  task automatic read_byte(input int pos);
    int a;
    a = pixel_addr(pos);
    if (a >= 0 && !written[a]) write_pixel(a, $urandom);
    send_item(1'b0, pos, $urandom_range(0, 131071), $urandom);
  endtask

  // Lets every read drain and any write still in the pipe land before the sizes change.
  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_sizes(input int sw, input int sh, input int nw, input int nh,
                           input rot_e r);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_SCREEN_W;
    cfg_wdata_i <= 10'(sw);
    @(posedge clk_i);
    cfg_idx_i <= REG_SCREEN_H;
    cfg_wdata_i <= 10'(sh);
    @(posedge clk_i);
    cfg_idx_i <= REG_NATIVE_W;
    cfg_wdata_i <= 10'(nw);
    @(posedge clk_i);
    cfg_idx_i <= REG_NATIVE_H;
    cfg_wdata_i <= 10'(nh);
    @(posedge clk_i);
    cfg_idx_i <= REG_ROTATION;
    cfg_wdata_i <= 10'(r);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_sw = clamp_size(sw);
    cur_sh = clamp_size(sh);
    cur_nw = clamp_size(nw);
    cur_nh = clamp_size(nh);
    cur_rot = r;
    file_bytes = 54 + ((cur_sw * 3 + 3) / 4) * 4 * cur_sh;
  endtask

  initial begin
    int sw_t[9] = '{1, 512, 0, 1023, 5, 37, 320, 2, 64};
    int sh_t[9] = '{1, 512, 0, 1023, 3, 100, 240, 9, 17};
    int nw_t[9] = '{1, 512, 0, 1023, 7, 100, 320, 9, 17};
    int nh_t[9] = '{1, 512, 0, 1023, 4, 37, 240, 2, 64};
    rot_e rot_t[9] = '{ROT_0, ROT_90, ROT_180, ROT_270, ROT_90, ROT_270, ROT_180,
                       ROT_90, ROT_0};
    int hdr_pos[16] = '{0, 1, 2, 3, 4, 5, 10, 14, 18, 19, 22, 26, 28, 34, 35, 53};
    int sel;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset sizes: header fields, extreme pixels, end of file.
    foreach (hdr_pos[k]) read_byte(hdr_pos[k]);
    write_pixel(239 * 320, 16'hFFFF);
    write_pixel(239 * 320 + 1, 16'hF800);
    write_pixel(239 * 320 + 2, 16'h07E0);
    for (int p = 54; p < 63; p++) read_byte(p);
    read_byte(file_bytes - 1);
    read_byte(file_bytes);
    read_byte(1048575);

    for (int ph = 0; ph < 9; ph++) begin
      drain_pipe();
      set_sizes(sw_t[ph], sh_t[ph], nw_t[ph], nh_t[ph], rot_t[ph]);
      if (ph == 2) hold_req = 1'b1;
      if (ph == 8) quiet = 1'b1;
      for (int n = 0; n < 55; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 20) write_pixel($urandom_range(0, 131071), $urandom);
        else if (sel < 30) read_byte($urandom_range(0, 53));
        else if (sel < 42) read_byte($urandom_range(file_bytes, 1048575));
        else read_byte($urandom_range(54, file_bytes - 1));
      end
    end

    drain_pipe();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
